// ===== rtl/msdr_pkg.sv =====
package msdr_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned RATIO_W  = 16;
  localparam int unsigned COUNT_W  = 2;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               error;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic range0;
    logic range1;
    logic range2;
    logic clear;
    logic div_start;
    logic div_step;
    logic res_short;
    logic res_sat;
    logic res_div;
    logic load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_curve;
    logic sat;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/msdr_dp.sv =====
module msdr_dp #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  msdr_pkg::cmd_t   cmd,
  output msdr_pkg::status_t status,
  input  msdr_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output msdr_pkg::out_t   out_data
);
  import msdr_pkg::*;

  localparam logic [SAMPLE_W-1:0] LIMIT = {SAMPLE_W{1'b1}} >> FRAC_BITS;

  logic [SAMPLE_W-1:0] previous_point;
  logic [SAMPLE_W-1:0] point_before_previous;
  logic [SAMPLE_W-1:0] best_slope;
  logic [SAMPLE_W-1:0] best_first;
  logic [SAMPLE_W-1:0] best_second;
  logic [SAMPLE_W-1:0] best_before;
  logic [SAMPLE_W-1:0] best_after;
  logic                before_valid;
  logic                after_valid;
  logic [COUNT_W-1:0]  points_seen;

  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;

  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W:0]   rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [RATIO_W-1:0]  res_ratio;
  logic                res_error;

  logic [SAMPLE_W-1:0] slope;
  logic [SAMPLE_W:0]   rem_shift;
  logic [SAMPLE_W:0]   rem_sub;
  logic [SAMPLE_W-1:0] numer;

  assign slope = (previous_point > in_data.sample) ? previous_point - in_data.sample
                                                   : in_data.sample - previous_point;
  assign rem_shift = {rem[SAMPLE_W-1:0], quot[SAMPLE_W-1]};
  assign rem_sub   = rem_shift - {1'b0, lo};
  assign numer     = hi << FRAC_BITS;

  assign status.short_curve = (points_seen < COUNT_W'(2));
  assign status.sat         = (lo == '0) || (hi >= LIMIT);
  assign status.div_last    = (div_cnt == '1);
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_point        <= '0;
      point_before_previous <= '0;
      best_slope            <= '0;
      best_first            <= '0;
      best_second           <= '0;
      best_before           <= '0;
      best_after            <= '0;
      before_valid          <= 1'b0;
      after_valid           <= 1'b0;
      points_seen           <= '0;
      div_cnt               <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (points_seen != '0) begin
          if (points_seen >= COUNT_W'(2) && !after_valid) begin
            best_after  <= in_data.sample;
            after_valid <= 1'b1;
          end
          if (points_seen == COUNT_W'(1)) begin
            best_slope   <= slope;
            best_first   <= previous_point;
            best_second  <= in_data.sample;
            before_valid <= 1'b0;
            after_valid  <= 1'b0;
          end else if (slope > best_slope) begin
            best_slope   <= slope;
            best_first   <= previous_point;
            best_second  <= in_data.sample;
            best_before  <= point_before_previous;
            before_valid <= 1'b1;
            after_valid  <= 1'b0;
          end
        end
        if (points_seen != '1) begin
          points_seen <= points_seen + COUNT_W'(1);
        end
        point_before_previous <= previous_point;
        previous_point        <= in_data.sample;
      end

      if (cmd.clear) begin
        previous_point        <= '0;
        point_before_previous <= '0;
        best_slope            <= '0;
        best_first            <= '0;
        best_second           <= '0;
        best_before           <= '0;
        best_after            <= '0;
        before_valid          <= 1'b0;
        after_valid           <= 1'b0;
        points_seen           <= '0;
      end

      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end

      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // range, divider and result datapath, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.range0) begin
      lo <= (best_first < best_second) ? best_first : best_second;
      hi <= (best_first > best_second) ? best_first : best_second;
    end else if (cmd.range1 && before_valid) begin
      if (best_before < lo) lo <= best_before;
      if (best_before > hi) hi <= best_before;
    end else if (cmd.range2 && after_valid) begin
      if (best_after < lo) lo <= best_after;
      if (best_after > hi) hi <= best_after;
    end

    // restoring division, one quotient bit per step
    if (cmd.div_start) begin
      quot <= numer;
      rem  <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[SAMPLE_W]) begin
        rem  <= rem_sub;
        quot <= {quot[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        quot <= {quot[SAMPLE_W-2:0], 1'b0};
      end
    end

    if (cmd.res_short) begin
      res_ratio <= RATIO_ONE;
      res_error <= 1'b1;
    end else if (cmd.res_sat) begin
      res_ratio <= RATIO_MAX;
      res_error <= 1'b0;
    end else if (cmd.res_div) begin
      res_ratio <= (quot > SAMPLE_W'(RATIO_MAX)) ? RATIO_MAX : quot[RATIO_W-1:0];
      res_error <= 1'b0;
    end

    if (cmd.load) begin
      out_data.ratio <= res_ratio;
      out_data.error <= res_error;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (points_seen == '0) && !before_valid && !after_valid)
    else $error("curve state not cleared");

  a_neighbours_need_three: assert property (@(posedge clk) disable iff (rst)
    (before_valid || after_valid) |-> (points_seen == COUNT_W'(3)))
    else $error("neighbour sample valid with fewer than three samples");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> status.out_free)
    else $error("result transaction overwritten");

  a_error_ratio: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> (out_data.ratio == RATIO_ONE))
    else $error("error result without unit ratio");

endmodule

// ===== rtl/msdr_ctrl.sv =====
module msdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last,
  input  msdr_pkg::status_t status,
  output msdr_pkg::cmd_t    cmd
);
  import msdr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANGE0,
    S_RANGE1,
    S_RANGE2,
    S_CHECK,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.accept = in_valid;
      S_RANGE0: begin
        cmd.range0 = 1'b1;
        if (status.short_curve) begin
          cmd.res_short = 1'b1;
          cmd.clear     = 1'b1;
        end
      end
      S_RANGE1: cmd.range1 = 1'b1;
      S_RANGE2: begin
        cmd.range2 = 1'b1;
        cmd.clear  = 1'b1;
      end
      S_CHECK: begin
        if (status.sat) begin
          cmd.res_sat = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV:    cmd.div_step = 1'b1;
      S_FIN:    cmd.res_div  = 1'b1;
      S_OUT:    cmd.load     = status.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_last) state <= S_RANGE0;
        end
        S_RANGE0: state <= status.short_curve ? S_OUT : S_RANGE1;
        S_RANGE1: state <= S_RANGE2;
        S_RANGE2: state <= S_CHECK;
        S_CHECK:  state <= status.sat ? S_OUT : S_DIV;
        S_DIV: begin
          if (status.div_last) state <= S_FIN;
        end
        S_FIN:    state <= S_OUT;
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_div_follows_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_DIV))
    else $error("divider started without stepping");

  a_last_closes_curve: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && in_last) |=> (state == S_RANGE0))
    else $error("closing transaction not finished");

endmodule

// ===== rtl/max_slope_dynamic_range_top.sv =====
// Streams a curve of unsigned 32-bit samples (last marks the final one), keeps the first
// steepest neighbour pair with the samples either side of it, and on the closing sample
// returns max/min of those samples as FRAC_BITS fixed point, saturated to 16 bits; a curve
// of fewer than two samples returns ratio 1 with error set. Samples are taken only while
// idle. A closing sample holds off input through the range search, the saturation check,
// the bit-per-cycle restoring divider, the finish step and the output register load.
// A saturated result skips the divider and finish step, and a short curve goes straight
// from the first range step to the output load. The hold-off lasts longer while an earlier
// result still waits in the output register. The divider loop makes the longest hold-off.
// A finished result sits in the output register while the next curve streams in.
module max_slope_dynamic_range_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  msdr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output msdr_pkg::out_t out_data
);
  import msdr_pkg::*;

  cmd_t    cmd;
  status_t status;

  msdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_last  (in_data.last),
    .status   (status),
    .cmd      (cmd)
  );

  msdr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
